// File: hw/rtl/spmq_pkg.sv
package spmq_pkg;

   // default sizes, overridable at the top level
   localparam int NUM_LEVELS_DEF = 4;
   localparam int RING_DEPTH_DEF = 16;

   // fixed field widths
   localparam int DATA_W      = 32;
   localparam int PRIO_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GOOD  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FILL_EMPTY   = 2'd0,
      FILL_PARTIAL = 2'd1,
      FILL_FULL    = 2'd2
   } fill_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FETCH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic fetch;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pop_hit;
   } dp_status_type;

endpackage

// File: hw/rtl/spmq_ctrl.sv
module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  spmq_pkg::dp_status_type dp_status,
   output spmq_pkg::ctrl_cmd_type  cmd
);

   spmq_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic load_out;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spmq_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = spmq_pkg::ST_ISSUE;
         end
         spmq_pkg::ST_ISSUE: begin
            if (out_free) begin
               state_in = dp_status.pop_hit ? spmq_pkg::ST_FETCH : spmq_pkg::ST_IDLE;
            end
         end
         spmq_pkg::ST_FETCH: begin
            state_in = spmq_pkg::ST_IDLE;
         end
         default: begin
            state_in = spmq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      load_out    = 1'b0;
      case (state_ff)
         spmq_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         spmq_pkg::ST_ISSUE: begin
            cmd.execute = out_free;
            load_out    = out_free && !dp_status.pop_hit;
         end
         spmq_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            load_out  = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spmq_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: hw/rtl/spmq_datapath.sv
module spmq_datapath #(
   parameter int NUM_LEVELS = spmq_pkg::NUM_LEVELS_DEF,
   parameter int RING_DEPTH = spmq_pkg::RING_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spmq_pkg::ctrl_cmd_type               cmd,
   output spmq_pkg::dp_status_type              dp_status,
   input  spmq_pkg::op_type                     opcode,
   input  logic [spmq_pkg::PRIO_W-1:0]          priority_req,
   input  logic signed [spmq_pkg::DATA_W-1:0]   data_in,
   output spmq_pkg::status_type                 status,
   output logic signed [spmq_pkg::DATA_W-1:0]   data_out,
   output logic [spmq_pkg::PRIO_W-1:0]          served_priority
);

   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int MEM_D  = NUM_LEVELS * RING_DEPTH;
   localparam int ADDR_W = $clog2(MEM_D);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   // captured item
   spmq_pkg::op_type                   op_ff;
   logic [LVL_W-1:0]                   lvl_ff;
   logic signed [spmq_pkg::DATA_W-1:0] word_ff;
   logic [LVL_W-1:0]                   lvl_in;

   // ring bookkeeping
   logic [PTR_W-1:0]  head_ff [NUM_LEVELS];
   logic [PTR_W-1:0]  tail_ff [NUM_LEVELS];
   spmq_pkg::fill_type fill_ff [NUM_LEVELS];

   logic signed [spmq_pkg::DATA_W-1:0] mem [MEM_D];
   logic signed [spmq_pkg::DATA_W-1:0] rd_ff;

   logic [LVL_W-1:0]  top_lvl;
   logic              any_filled;
   logic [LVL_W-1:0]  acc_lvl;
   logic [PTR_W-1:0]  acc_ptr;
   logic [PTR_W-1:0]  nxt_ptr;
   logic [ADDR_W-1:0] acc_addr;
   logic              is_pop;
   logic              push_ok;
   logic              pop_ok;

   // clamp the requested level onto the last ring
   always_comb begin
      if (int'(priority_req) >= NUM_LEVELS) begin
         lvl_in = LVL_W'(NUM_LEVELS - 1);
      end else begin
         lvl_in = LVL_W'(priority_req);
      end
   end

   // highest non-empty level
   always_comb begin
      top_lvl    = '0;
      any_filled = 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (fill_ff[i] != spmq_pkg::FILL_EMPTY) begin
            top_lvl    = LVL_W'(i);
            any_filled = 1'b1;
         end
      end
   end

   assign is_pop            = (op_ff == spmq_pkg::OP_POP);
   assign pop_ok            = is_pop && any_filled;
   assign push_ok           = !is_pop && (fill_ff[lvl_ff] != spmq_pkg::FILL_FULL);
   assign dp_status.pop_hit = pop_ok;

   assign acc_lvl  = is_pop ? top_lvl : lvl_ff;
   assign acc_ptr  = is_pop ? head_ff[top_lvl] : tail_ff[lvl_ff];
   assign nxt_ptr  = (acc_ptr == PTR_LAST) ? '0 : acc_ptr + 1'b1;
   assign acc_addr = ADDR_W'(ADDR_W'(acc_lvl) * ADDR_W'(RING_DEPTH)) + ADDR_W'(acc_ptr);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= opcode;
         lvl_ff  <= lvl_in;
         word_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= spmq_pkg::FILL_EMPTY;
         end
      end else if (cmd.execute) begin
         if (push_ok) begin
            tail_ff[lvl_ff] <= nxt_ptr;
            fill_ff[lvl_ff] <= (nxt_ptr == head_ff[lvl_ff]) ?
                               spmq_pkg::FILL_FULL : spmq_pkg::FILL_PARTIAL;
         end else if (pop_ok) begin
            head_ff[top_lvl] <= nxt_ptr;
            fill_ff[top_lvl] <= (nxt_ptr == tail_ff[top_lvl]) ?
                                spmq_pkg::FILL_EMPTY : spmq_pkg::FILL_PARTIAL;
         end
      end
   end

   // ring storage, one access a cycle
   always_ff @(posedge clock) begin
      if (cmd.execute && push_ok) begin
         mem[acc_addr] <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && pop_ok) begin
         rd_ff <= mem[acc_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         data_out <= '0;
         if (is_pop) begin
            status          <= any_filled ? spmq_pkg::STATUS_GOOD : spmq_pkg::STATUS_EMPTY;
            served_priority <= any_filled ? spmq_pkg::PRIO_W'(top_lvl) : '0;
         end else begin
            status          <= push_ok ? spmq_pkg::STATUS_GOOD : spmq_pkg::STATUS_FULL;
            served_priority <= spmq_pkg::PRIO_W'(lvl_ff);
         end
      end else if (cmd.fetch) begin
         data_out <= rd_ff;
      end
   end

endmodule

// File: hw/rtl/strict_priority_multi_queue_top.sv
// strict priority multi-queue
// a bank of NUM_LEVELS ring fifos of RING_DEPTH words each, one per level
// req channel: one item is a push (word into the ring of its level) or a pop
//   (oldest word of the highest non-empty level); levels past the last ring
//   are clamped onto it
// rsp channel: exactly one item per request, in request order, carrying
//   status (ok / ring full / all empty), the popped word and the level served
// result path: a push result is registered into the output straight from the
//   issue state, a pop one after the registered ring read and the fetch state
// sequencing: one item at a time through the state machine; the ring memory
//   has a single port
// reset: synchronous, clears all head and tail pointers and marks every ring
//   empty at once; no clearing pass, ring contents stay as they are
// stall: the result sits in an output register; a new item is still accepted
//   while it waits, and that item's ring access holds off until the waiting
//   result is taken
module strict_priority_multi_queue_top #(
   parameter int NUM_LEVELS = spmq_pkg::NUM_LEVELS_DEF,
   parameter int RING_DEPTH = spmq_pkg::RING_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // priority_req [1:0], data_in [33:2], zero [39:34]
   input  logic [spmq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // opcode [0]
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // data_out [31:0], served_priority [33:32], zero [39:34]
   output logic [spmq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status [1:0]
   output logic [spmq_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int PW = spmq_pkg::PRIO_W;
   localparam int DW = spmq_pkg::DATA_W;

   spmq_pkg::ctrl_cmd_type  cmd;
   spmq_pkg::dp_status_type dp_status;
   spmq_pkg::status_type    status;
   logic signed [DW-1:0]    data_out;
   logic [PW-1:0]           served_priority;

   // sequencing and output-valid tracking
   spmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   // ring state, level select, storage and result register
   spmq_datapath #(
      .NUM_LEVELS (NUM_LEVELS),
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .opcode          (spmq_pkg::op_type'(req_tuser[0])),
      .priority_req    (req_tdata[PW-1:0]),
      .data_in         (req_tdata[PW+DW-1:PW]),
      .status          (status),
      .data_out        (data_out),
      .served_priority (served_priority)
   );

   // pack the result item
   assign rsp_tdata = {{(spmq_pkg::RSP_TDATA_W - DW - PW){1'b0}}, served_priority, data_out};
   assign rsp_tuser = status;

endmodule

// File: hw/rtl/spmq_checker.sv
module spmq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [spmq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [spmq_pkg::STATUS_W-1:0]     rsp_tuser
);

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // an empty pop reports no word and level zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == spmq_pkg::STATUS_EMPTY) |-> (rsp_tdata[33:0] == '0))
      else $error("empty pop carries data");

   // a rejected push reports no word
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == spmq_pkg::STATUS_FULL) |-> (rsp_tdata[31:0] == '0))
      else $error("rejected push carries data");

   // a request is never taken in the cycle after another one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

endmodule

bind strict_priority_multi_queue_top spmq_checker u_spmq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/spmq_tb_pkg.sv
package spmq_tb_pkg;
   import spmq_pkg::*;

   localparam int LEVELS = NUM_LEVELS_DEF;
   localparam int DEPTH  = RING_DEPTH_DEF;
   localparam int PTR_W  = $clog2(DEPTH);

   typedef struct {
      status_type          status;
      logic [DATA_W-1:0]   word;
      logic [PRIO_W-1:0]   level;
   } queue_outcome_type;

   class queue_scoreboard;
      logic [DATA_W-1:0] ring [LEVELS][DEPTH];
      logic [PTR_W-1:0]  rd_ptr [LEVELS];
      logic [PTR_W-1:0]  wr_ptr [LEVELS];
      fill_type          mark [LEVELS];
      queue_outcome_type awaited [$];
      int                errors;

      function new();
         for (int l = 0; l < LEVELS; l++) begin
            rd_ptr[l] = '0;
            wr_ptr[l] = '0;
            mark[l]   = FILL_EMPTY;
            for (int s = 0; s < DEPTH; s++) ring[l][s] = '0;
         end
         errors = 0;
      endfunction

      function logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
         return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      endfunction

      // works out the result of one accepted request and queues it
      function void note_request(op_type op, logic [PRIO_W-1:0] prio,
                                 logic [DATA_W-1:0] word);
         queue_outcome_type res;
         int                lvl;
         bit                found;
         res.status = STATUS_GOOD;
         res.word   = '0;
         res.level  = '0;
         if (op == OP_PUSH) begin
            // levels past the last ring land on it
            lvl = (int'(prio) >= LEVELS) ? LEVELS - 1 : int'(prio);
            res.level = PRIO_W'(lvl);
            if (mark[lvl] == FILL_FULL) begin
               res.status = STATUS_FULL;
            end else begin
               ring[lvl][wr_ptr[lvl]] = word;
               wr_ptr[lvl] = next_slot(wr_ptr[lvl]);
               mark[lvl] = (wr_ptr[lvl] == rd_ptr[lvl]) ? FILL_FULL : FILL_PARTIAL;
            end
         end else begin
            found = 1'b0;
            for (int l = LEVELS - 1; l >= 0 && !found; l--) begin
               if (mark[l] != FILL_EMPTY) begin
                  res.word  = ring[l][rd_ptr[l]];
                  res.level = PRIO_W'(l);
                  rd_ptr[l] = next_slot(rd_ptr[l]);
                  mark[l] = (rd_ptr[l] == wr_ptr[l]) ? FILL_EMPTY : FILL_PARTIAL;
                  found = 1'b1;
               end
            end
            if (!found) res.status = STATUS_EMPTY;
         end
         awaited.push_back(res);
      endfunction

      task report(string what);
         errors++;
         $display("tb mismatch: %s", what);
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] word,
                          logic [PRIO_W-1:0] level);
         queue_outcome_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result status %0d word %h level %0d",
                             status, word, level));
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
         if (word !== want.word)
            report($sformatf("data_out %h, expected %h", word, want.word));
         if (level !== want.level)
            report($sformatf("served_priority %0d, expected %0d", level, want.level));
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

endpackage

// File: tb/tb.sv
module tb;
   import spmq_pkg::*;
   import spmq_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int CHUNK        = 50;
   localparam int CYCLE_LIMIT  = 400000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // priority_req [1:0], data_in [33:2], zero [39:34]
   logic [REQ_TDATA_W-1:0]   req_tdata;
   // opcode [0]
   logic [0:0]               req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // data_out [31:0], served_priority [33:32], zero [39:34]
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   // status [1:0]
   logic [STATUS_W-1:0]      rsp_tuser;

   // stretches with no idling on the request or the result side
   bit                       source_calm = 1'b0;
   bit                       sink_calm   = 1'b0;
   int unsigned              cycles      = 0;
   queue_scoreboard          board;

   strict_priority_multi_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hang guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // mostly no gap, sometimes a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side: sampled at the rising edge, checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tuser, rsp_tdata[DATA_W-1:0],
                              rsp_tdata[DATA_W+PRIO_W-1:DATA_W]);
   end

   // result side back-pressure, changed at the falling edge only
   initial begin : sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
            if (!sink_calm) stall_left = pick_gap();
         end
      end
   end

   // one item on the request side; returns at the falling edge after acceptance,
   // leaving tvalid high so that back-to-back items go out with no drop in tvalid
   task automatic send_item(op_type op, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] word);
      int gap;
      gap = source_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {{(REQ_TDATA_W - DATA_W - PRIO_W){1'b0}}, word, prio};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, prio, word);
      @(negedge clock);
   endtask

   initial begin : stimulus
      op_type            op;
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] word;
      int                push_share;
      int                focus;
      int                sent;

      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_PUSH;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // pop with every ring empty, ignored fields set
      send_item(OP_POP, 2'd3, 32'hFFFF_FFFF);
      // one word per level at the extremes of the data range
      send_item(OP_PUSH, 2'd0, 32'h8000_0000);
      send_item(OP_PUSH, 2'd1, 32'h7FFF_FFFF);
      send_item(OP_PUSH, 2'd2, 32'h0000_0000);
      send_item(OP_PUSH, 2'd3, 32'hFFFF_FFFF);
      // drained highest level first, then all empty again
      repeat (LEVELS + 1) send_item(OP_POP, 2'd0, 32'h0);
      // fill one ring to the brim, then a rejected push
      for (int i = 0; i < DEPTH; i++)
         send_item(OP_PUSH, 2'd2, 32'h1111_1111 * i ^ 32'hA5A5_0000);
      send_item(OP_PUSH, 2'd2, 32'hDEAD_BEEF);

      // random part in chunks, each with its own push share and level focus so that
      // rings fill up, wrap and drain
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: push_share = 25;
            1: push_share = 50;
            default: push_share = 85;
         endcase
         focus       = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, LEVELS - 1);
         source_calm = ($urandom_range(0, 3) == 0);
         sink_calm   = ($urandom_range(0, 3) == 0);
         repeat (CHUNK) begin
            op   = ($urandom_range(0, 99) < push_share) ? OP_PUSH : OP_POP;
            prio = (focus < 0 || $urandom_range(0, 4) == 0) ? PRIO_W'($urandom)
                                                            : PRIO_W'(focus);
            case ($urandom_range(0, 15))
               0: word = 32'h8000_0000;
               1: word = 32'h7FFF_FFFF;
               2: word = 32'h0000_0000;
               3: word = 32'hFFFF_FFFF;
               default: word = $urandom;
            endcase
            send_item(op, prio, word);
            sent++;
         end
      end
      req_tvalid = 1'b0;

      // drain, then a few cycles to catch stray results
      while (board.pending() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (board.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
